// ===== hw/rtl/pulse_noise_excitation_defines.svh =====
// Assertion macros for the pulse/noise excitation RTL.
`ifndef PULSE_NOISE_EXCITATION_DEFINES_SVH
`define PULSE_NOISE_EXCITATION_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define PNE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pulse_noise_excitation: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define PNE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pulse_noise_excitation: next-cycle check failed");

`endif

// ===== hw/rtl/pne_pkg.sv =====
package pne_pkg;

    localparam int unsigned PITCH_W    = 24;
    localparam int unsigned NOISE_W    = 16;
    localparam int unsigned EXC_W      = 24;
    localparam int unsigned PULSE_W    = 20;
    localparam int unsigned PHASE_W    = 32;
    localparam int unsigned QUO_W      = 33;
    localparam int unsigned DIV_REM_W  = 23;
    localparam int unsigned SQ_REM_W   = 21;
    localparam int unsigned RAD_W      = 40;
    localparam int unsigned CNT_W      = 6;
    localparam int unsigned STEP_W     = 3;
    localparam int unsigned OUT_DATA_W = 88;

    // Divider runs 33 passes (counter 32 down to 0); square root uses the last 20.
    localparam logic [CNT_W-1:0] ITER_LAST  = 6'd32;
    localparam logic [CNT_W-1:0] SQRT_START = 6'd19;

    localparam logic [PHASE_W-1:0] PHASE_ONE = 32'h0100_0000;
    localparam logic [PHASE_W-1:0] PHASE_MAX = 32'hFFFF_FFFF;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_FETCH    = 3'd0;
    localparam step_t STEP_CLASSIFY = 3'd1;
    localparam step_t STEP_ITER     = 3'd2;
    localparam step_t STEP_UPDATE   = 3'd3;
    localparam step_t STEP_EMIT     = 3'd4;
    localparam step_t STEP_WAIT     = 3'd5;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_NO_INPUT,
        COND_SPECIAL,
        COND_ITER_MORE,
        COND_OUT_FREE,
        COND_ALWAYS
    } cond_t;

    typedef struct packed {
        logic  accept;
        logic  classify;
        logic  iterate;
        logic  update;
        logic  emit;
        cond_t cond;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic special;
        logic iter_more;
        logic out_free;
    } flags_t;

    // Microprogram: branch to target when cond holds, else fall through.
    function automatic ctrl_t ucode(input step_t step);
        ctrl_t w;
        w = '0;
        unique case (step)
            STEP_FETCH:
            begin
                w.accept = 1'b1;
                w.cond   = COND_NO_INPUT;
                w.target = STEP_FETCH;
            end
            STEP_CLASSIFY:
            begin
                w.classify = 1'b1;
                w.cond     = COND_SPECIAL;
                w.target   = STEP_EMIT;
            end
            STEP_ITER:
            begin
                w.iterate = 1'b1;
                w.cond    = COND_ITER_MORE;
                w.target  = STEP_ITER;
            end
            STEP_UPDATE:
            begin
                w.update = 1'b1;
                w.cond   = COND_NONE;
                w.target = STEP_FETCH;
            end
            STEP_EMIT:
            begin
                w.emit   = 1'b1;
                w.cond   = COND_OUT_FREE;
                w.target = STEP_FETCH;
            end
            STEP_WAIT:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_EMIT;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/pulse_noise_excitation.sv =====
// A voiced pitch goes fetch, classify, 33-pass shift-subtract reciprocal loop
// (square root runs alongside it), update, emit; unvoiced, negative or zero
// pitch goes from classify straight to emit. No new input beat is accepted
// until the last one is emitted, and emit waits while a held beat is not taken.
// Reset: phase at 1.0, unvoiced marker 0, output register empty.
`include "pulse_noise_excitation_defines.svh"

module pulse_noise_excitation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data,       // unvoiced_marker
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // pitch_period[23:0], noise_sample[39:24]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // excitation[23:0], pulse_value[43:24], noise_echo[59:44], pitch_echo[83:60], zero pad
    output logic [87:0] m_axis_tdata,
    output logic [0:0]  m_axis_tuser    // status
);

    logic [pne_pkg::PITCH_W-1:0]    marker_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [pne_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                           out_user_reg;

    pne_pkg::ctrl_t  ctrl;
    pne_pkg::flags_t flags;

    logic                         in_fire;
    logic                         out_free;
    logic                         emit_fire;
    logic                         special;
    logic                         iter_more;
    logic [pne_pkg::PITCH_W-1:0]  pitch_q;
    logic [pne_pkg::NOISE_W-1:0]  noise_q;
    logic [pne_pkg::EXC_W-1:0]    exc_q;
    logic [pne_pkg::PULSE_W-1:0]  pulse_q;
    logic                         status_q;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = ctrl.accept;
    assign in_fire       = s_axis_tvalid && ctrl.accept;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign emit_fire     = ctrl.emit && out_free;

    assign flags.in_valid  = s_axis_tvalid;
    assign flags.special   = special;
    assign flags.iter_more = iter_more;
    assign flags.out_free  = out_free;

    pne_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    pne_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .in_fire   (in_fire),
        .pitch_in  (s_axis_tdata[23:0]),
        .noise_in  (s_axis_tdata[39:24]),
        .marker    (marker_reg),
        .special   (special),
        .iter_more (iter_more),
        .pitch_q   (pitch_q),
        .noise_q   (noise_q),
        .exc_q     (exc_q),
        .pulse_q   (pulse_q),
        .status_q  (status_q)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                marker_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_data_reg <= {4'd0, pitch_q, noise_q, pulse_q, exc_q};
            out_user_reg <= status_q;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_user_reg;

    `PNE_ASSERT_NEXT(a_accept_leaves_fetch, clk, rst_n,
        s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `PNE_ASSERT_NEXT(a_emit_loads_output, clk, rst_n, emit_fire, m_axis_tvalid)
    `PNE_ASSERT_NOW(a_error_is_silent, clk, rst_n, m_axis_tvalid && m_axis_tuser[0],
        (m_axis_tdata[23:0] == 24'd0) && (m_axis_tdata[43:24] == 20'd0))
    `PNE_ASSERT_NOW(a_pulse_drives_exc, clk, rst_n,
        m_axis_tvalid && (m_axis_tdata[43:24] != 20'd0),
        m_axis_tdata[23:0] == {4'd0, m_axis_tdata[43:24]})

endmodule

// ===== hw/rtl/pne_seq.sv =====
module pne_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  pne_pkg::flags_t flags,
    output pne_pkg::ctrl_t  ctrl
);

    pne_pkg::step_t step_reg;
    pne_pkg::step_t step_next;
    logic           take;

    always_comb
    begin
        ctrl = pne_pkg::ucode(step_reg);
        unique case (ctrl.cond)
            pne_pkg::COND_NONE:      take = 1'b0;
            pne_pkg::COND_NO_INPUT:  take = !flags.in_valid;
            pne_pkg::COND_SPECIAL:   take = flags.special;
            pne_pkg::COND_ITER_MORE: take = flags.iter_more;
            pne_pkg::COND_OUT_FREE:  take = flags.out_free;
            pne_pkg::COND_ALWAYS:    take = 1'b1;
            default:                 take = 1'b1;
        endcase
        step_next = take ? ctrl.target : step_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= pne_pkg::STEP_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== hw/rtl/pne_dp.sv =====
module pne_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pne_pkg::ctrl_t                ctrl,
    input  logic                          in_fire,
    input  logic [pne_pkg::PITCH_W-1:0]   pitch_in,
    input  logic [pne_pkg::NOISE_W-1:0]   noise_in,
    input  logic [pne_pkg::PITCH_W-1:0]   marker,
    output logic                          special,
    output logic                          iter_more,
    output logic [pne_pkg::PITCH_W-1:0]   pitch_q,
    output logic [pne_pkg::NOISE_W-1:0]   noise_q,
    output logic [pne_pkg::EXC_W-1:0]     exc_q,
    output logic [pne_pkg::PULSE_W-1:0]   pulse_q,
    output logic                          status_q
);

    logic [pne_pkg::PITCH_W-1:0]   pitch_reg;
    logic [pne_pkg::NOISE_W-1:0]   noise_reg;
    logic [pne_pkg::PHASE_W-1:0]   phase_reg, phase_next;
    logic [pne_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [pne_pkg::DIV_REM_W-1:0] div_rem_reg, div_rem_next;
    logic [pne_pkg::QUO_W-1:0]     quo_reg, quo_next;
    logic [pne_pkg::SQ_REM_W-1:0]  sq_rem_reg, sq_rem_next;
    logic [pne_pkg::PULSE_W-1:0]   root_reg, root_next;
    logic [pne_pkg::RAD_W-1:0]     rad_reg, rad_next;
    logic [pne_pkg::EXC_W-1:0]     exc_reg, exc_next;
    logic [pne_pkg::PULSE_W-1:0]   pulse_reg, pulse_next;
    logic                          status_reg, status_next;

    logic                            neg, unv, zero;
    logic [pne_pkg::DIV_REM_W:0]     div_sh;
    logic [pne_pkg::DIV_REM_W:0]     divisor;
    logic [pne_pkg::SQ_REM_W+1:0]    sq_sh;
    logic [pne_pkg::SQ_REM_W+1:0]    trial;
    logic                            pulse_fire;
    logic [pne_pkg::PHASE_W-1:0]     phase_base;
    logic [pne_pkg::PHASE_W+1:0]     phase_sum;

    // Negative first, then marker, then zero pitch.
    assign neg       = pitch_reg[pne_pkg::PITCH_W-1];
    assign unv       = !neg && (pitch_reg == marker);
    assign zero      = !neg && !unv && (pitch_reg == '0);
    assign special   = neg || unv || zero;
    assign iter_more = (cnt_reg != '0);

    assign divisor = {1'b0, pitch_reg[pne_pkg::PITCH_W-2:0]};
    // Dividend is 2^32: only the first pass shifts in a one.
    assign div_sh  = {div_rem_reg, (cnt_reg == pne_pkg::ITER_LAST)};
    assign sq_sh   = {sq_rem_reg, rad_reg[pne_pkg::RAD_W-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};

    assign pulse_fire = (phase_reg >= pne_pkg::PHASE_ONE);
    assign phase_base = pulse_fire ? phase_reg - pne_pkg::PHASE_ONE : phase_reg;
    assign phase_sum  = {2'b00, phase_base} + {1'b0, quo_reg};

    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        div_rem_next = div_rem_reg;
        quo_next     = quo_reg;
        sq_rem_next  = sq_rem_reg;
        root_next    = root_reg;
        rad_next     = rad_reg;
        exc_next     = exc_reg;
        pulse_next   = pulse_reg;
        status_next  = status_reg;

        if (ctrl.classify)
        begin
            cnt_next     = pne_pkg::ITER_LAST;
            div_rem_next = '0;
            quo_next     = '0;
            sq_rem_next  = '0;
            root_next    = '0;
            // Radicand is pitch << 16.
            rad_next     = {1'b0, pitch_reg[pne_pkg::PITCH_W-2:0], 16'd0};
            exc_next     = unv ? {{8{noise_reg[pne_pkg::NOISE_W-1]}}, noise_reg} : '0;
            pulse_next   = '0;
            status_next  = neg || zero;
            if (unv)
            begin
                phase_next = pne_pkg::PHASE_ONE;
            end
        end

        if (ctrl.iterate)
        begin
            cnt_next = cnt_reg - 6'd1;
            if (div_sh >= divisor)
            begin
                div_rem_next = pne_pkg::DIV_REM_W'(div_sh - divisor);
                quo_next     = {quo_reg[pne_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                div_rem_next = div_sh[pne_pkg::DIV_REM_W-1:0];
                quo_next     = {quo_reg[pne_pkg::QUO_W-2:0], 1'b0};
            end
            if (cnt_reg <= pne_pkg::SQRT_START)
            begin
                rad_next = {rad_reg[pne_pkg::RAD_W-3:0], 2'b00};
                if (sq_sh >= trial)
                begin
                    sq_rem_next = pne_pkg::SQ_REM_W'(sq_sh - trial);
                    root_next   = {root_reg[pne_pkg::PULSE_W-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_next = sq_sh[pne_pkg::SQ_REM_W-1:0];
                    root_next   = {root_reg[pne_pkg::PULSE_W-2:0], 1'b0};
                end
            end
        end

        if (ctrl.update)
        begin
            // Saturate the phase at its maximum.
            if (phase_sum > {2'b00, pne_pkg::PHASE_MAX})
            begin
                phase_next = pne_pkg::PHASE_MAX;
            end
            else
            begin
                phase_next = phase_sum[pne_pkg::PHASE_W-1:0];
            end
            exc_next    = pulse_fire ? {4'd0, root_reg} : '0;
            pulse_next  = pulse_fire ? root_reg : '0;
            status_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pne_pkg::PHASE_ONE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pitch_reg <= pitch_in;
            noise_reg <= noise_in;
        end
        div_rem_reg <= div_rem_next;
        quo_reg     <= quo_next;
        sq_rem_reg  <= sq_rem_next;
        root_reg    <= root_next;
        rad_reg     <= rad_next;
        exc_reg     <= exc_next;
        pulse_reg   <= pulse_next;
        status_reg  <= status_next;
    end

    assign pitch_q  = pitch_reg;
    assign noise_q  = noise_reg;
    assign exc_q    = exc_reg;
    assign pulse_q  = pulse_reg;
    assign status_q = status_reg;

endmodule
